[src/spc_pkg.sv]
package spc_pkg;

   // command codes carried on req_tuser
   localparam logic [1:0] OP_NONE        = 2'd0;
   localparam logic [1:0] OP_SINGLE_STEP = 2'd1;
   localparam logic [1:0] OP_HOME        = 2'd2;
   localparam logic [1:0] OP_GOTO        = 2'd3;

   // configuration register indexes
   localparam logic [7:0] REG_STEP_DIVIDER = 8'd0;
   localparam logic [7:0] REG_HOLD_TICKS   = 8'd1;

   localparam logic [7:0]  STEP_DIVIDER_RESET = 8'd1;
   localparam logic [15:0] HOLD_TICKS_RESET   = 16'd100;

   typedef struct packed {
      logic [1:0]  command;
      logic        step_direction;
      logic [15:0] target_position;
      logic        limit_switch;
   } req_type;

   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic [15:0] position;
      logic        command_active;
      logic        moving;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  step_divider;
      logic [15:0] hold_ticks;
   } cfg_type;

   // coil drive per phase
   function automatic logic [3:0] coil_lookup(input logic [1:0] ph);
      logic [3:0] pat;
      case (ph)
         2'd0: pat = 4'd1;
         2'd1: pat = 4'd4;
         2'd2: pat = 4'd2;
         2'd3: pat = 4'd8;
         default: pat = 4'd0;
      endcase
      return pat;
   endfunction

endpackage

[src/spc_tick_core.sv]
module spc_tick_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick,
   input  spc_pkg::req_type  req,
   input  spc_pkg::cfg_type  cfg,
   output spc_pkg::rsp_type  rsp
);

   logic [1:0]  act_cmd_ff, act_cmd_in;
   logic        running_ff, running_in;
   logic        direction_ff, direction_in;
   logic [7:0]  div_count_ff, div_count_in;
   logic [15:0] hold_count_ff, hold_count_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] goal_ff, goal_in;

   always_comb begin
      act_cmd_in    = act_cmd_ff;
      running_in    = running_ff;
      direction_in  = direction_ff;
      div_count_in  = div_count_ff;
      hold_count_in = hold_count_ff;
      phase_in      = phase_ff;
      position_in   = position_ff;
      goal_in       = goal_ff;
      rsp           = '0;

      // new command replaces the active one
      if (req.command != spc_pkg::OP_NONE) begin
         act_cmd_in = req.command;
         if (req.command == spc_pkg::OP_SINGLE_STEP) begin
            direction_in = req.step_direction;
         end
         if (req.command == spc_pkg::OP_GOTO) begin
            goal_in = req.target_position;
         end
      end

      case (act_cmd_in)
         spc_pkg::OP_SINGLE_STEP: begin
            hold_count_in = cfg.hold_ticks;
            phase_in      = direction_in ? phase_in + 2'd1 : phase_in - 2'd1;
            position_in   = direction_in ? position_in + 16'd1 : position_in - 16'd1;
            act_cmd_in    = spc_pkg::OP_NONE;
         end
         spc_pkg::OP_HOME: begin
            direction_in = 1'b0;
            running_in   = 1'b1;
            if (req.limit_switch) begin
               running_in  = 1'b0;
               act_cmd_in  = spc_pkg::OP_NONE;
               position_in = '0;
            end
         end
         spc_pkg::OP_GOTO: begin
            if (position_in == goal_in) begin
               running_in = 1'b0;
               act_cmd_in = spc_pkg::OP_NONE;
            end else begin
               direction_in = position_in < goal_in;
               running_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // divider paced step while running
      if (running_in) begin
         if (div_count_in == 8'd0) begin
            div_count_in  = cfg.step_divider;
            hold_count_in = cfg.hold_ticks;
            phase_in      = direction_in ? phase_in + 2'd1 : phase_in - 2'd1;
            position_in   = direction_in ? position_in + 16'd1 : position_in - 16'd1;
         end else begin
            div_count_in = div_count_in - 8'd1;
         end
      end

      if (hold_count_in != 16'd0) begin
         hold_count_in    = hold_count_in - 16'd1;
         rsp.coil_pattern = spc_pkg::coil_lookup(phase_in);
      end

      rsp.position       = position_in;
      rsp.command_active = act_cmd_in != spc_pkg::OP_NONE;
      rsp.moving         = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_cmd_ff    <= spc_pkg::OP_NONE;
         running_ff    <= 1'b0;
         direction_ff  <= 1'b0;
         div_count_ff  <= '0;
         hold_count_ff <= '0;
         phase_ff      <= '0;
         position_ff   <= '0;
         goal_ff       <= '0;
      end else if (tick) begin
         act_cmd_ff    <= act_cmd_in;
         running_ff    <= running_in;
         direction_ff  <= direction_in;
         div_count_ff  <= div_count_in;
         hold_count_ff <= hold_count_in;
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         goal_ff       <= goal_in;
      end
   end

endmodule

[src/stepper_position_controller_top.sv]
// stepper position controller: one control tick per req transaction, one rsp per tick
// path: a req passes the input register, then the result register, before its rsp
// transaction is presented on rsp_tvalid and rsp_tdata
// throughput: one transaction per cycle, set by the single-pass tick logic
// between the input and result registers; rsp stalls back up through the input register
// reset: synchronous active high; clears motion state, step_divider to 1, hold_ticks to 100
module stepper_position_controller_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // step_direction[0], target_position[16:1], limit_switch[17]
   input  logic [1:0]  req_tuser,   // command[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // coil_pattern[3:0], position[19:4],
                                    // command_active[20], moving[21]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   // input register
   logic             in_valid_ff, in_valid_in;
   spc_pkg::req_type in_req_ff, in_req_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   spc_pkg::rsp_type out_rsp_ff, out_rsp_in;

   // configuration registers
   spc_pkg::cfg_type cfg_ff, cfg_in;

   spc_pkg::rsp_type tick_rsp;
   logic             advance;

   // the held item moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_tready) begin
         in_valid_in               = req_tvalid;
         in_req_in.command         = req_tuser;
         in_req_in.step_direction  = req_tdata[0];
         in_req_in.target_position = req_tdata[16:1];
         in_req_in.limit_switch    = req_tdata[17];
      end

      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = tick_rsp;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // writes to indexes outside the register list are dropped
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            spc_pkg::REG_STEP_DIVIDER: cfg_in.step_divider = csr_data[7:0];
            spc_pkg::REG_HOLD_TICKS:   cfg_in.hold_ticks   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cfg_ff.step_divider <= spc_pkg::STEP_DIVIDER_RESET;
         cfg_ff.hold_ticks   <= spc_pkg::HOLD_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   // motion state and the per-tick update
   spc_tick_core u_core (
      .clock (clock),
      .reset (reset),
      .tick  (advance),
      .req   (in_req_ff),
      .cfg   (cfg_ff),
      .rsp   (tick_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_rsp_ff.moving, out_rsp_ff.command_active,
                        out_rsp_ff.position, out_rsp_ff.coil_pattern};

endmodule

[src/spc_checker.sv]
module spc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // at most one coil driven at a time
   a_coil_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[3:0]))
      else $error("more than one coil driven");

   // an active home or goto always leaves the motor running
   a_active_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[21])
      else $error("command active without motion");

   // with the result side empty the input is never blocked
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result register");

endmodule

bind stepper_position_controller_top spc_checker u_spc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
